@@ design/tsr_pkg.sv @@
// Package for the TCP stream reorder block.
// Holds the opcodes, result kinds, record types and the command and status
// structs that join the controller and the datapath. No dependencies.
package tsr_pkg;

	localparam logic [1:0] OP_SEGMENT = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_FINISH  = 2'd2;

	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_ABSORB  = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [15:0] payload_len;
		logic        syn_flag;
		logic        fin_flag;
		logic        rst_flag;
		logic [15:0] packet_tag;
	} seg_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] out_tag;
		logic [31:0] conv_serial;
		logic        upstream;
		logic        conv_started;
		logic        conv_finished;
		logic [31:0] delivered_count;
		logic        count_tick;
		logic        overflow;
		logic        last;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] client_addr;
		logic [31:0] server_addr;
		logic [31:0] port_pair;
		logic [31:0] conv_number;
		logic [31:0] next_up;
		logic [31:0] next_down;
		logic        up_known;
		logic        down_known;
	} conv_ent_t;

	typedef struct packed {
		logic capture;
		logic start_clr;
		logic tables_clr;
		logic sweep;
		logic sweep_rst;
		logic cscan_rst;
		logic cscan;
		logic take_hit;
		logic take_new;
		logic dir;
		logic deliver_in;
		logic deliver_held;
		logic absorb;
		logic absorb_noconv;
		logic absorb_ovf;
		logic hold_ins;
		logic status;
		logic hscan_rst;
		logic hscan_find;
		logic purge_dup;
		logic purge_conv;
		logic wb;
		logic push_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       close;
		logic       sweep_done;
		logic       cscan_done;
		logic       hit;
		logic       conv_free;
		logic       seq_eq;
		logic       seq_older;
		logic       hold_free;
		logic       hscan_done;
		logic       found;
		logic       held_moves;
		logic       can_load;
		logic       can_push;
	} dp_stat_t;

endpackage

@@ design/tsr_if.sv @@
// Request channel interfaces of the TCP stream reorder block.
// The segment channel carries input items, the result channel the results.
// No dependencies.
interface tsr_seg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] seq_num;
	logic [15:0] payload_len;
	logic        syn_flag;
	logic        fin_flag;
	logic        rst_flag;
	logic [15:0] packet_tag;

	modport source (output valid, opcode, src_addr, dst_addr, src_port, dst_port, seq_num,
		payload_len, syn_flag, fin_flag, rst_flag, packet_tag, input ready);
	modport sink (input valid, opcode, src_addr, dst_addr, src_port, dst_port, seq_num,
		payload_len, syn_flag, fin_flag, rst_flag, packet_tag, output ready);
endinterface

interface tsr_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] out_tag;
	logic [31:0] conv_serial;
	logic        upstream;
	logic        conv_started;
	logic        conv_finished;
	logic [31:0] delivered_count;
	logic        count_tick;
	logic        overflow;
	logic        last;

	modport source (output valid, result_kind, out_tag, conv_serial, upstream, conv_started,
		conv_finished, delivered_count, count_tick, overflow, last, input ready);
	modport sink (input valid, result_kind, out_tag, conv_serial, upstream, conv_started,
		conv_finished, delivered_count, count_tick, overflow, last, output ready);
endinterface

@@ design/tsr_ram.sv @@
// Generic single write port RAM with a registered read port.
// Used for the conversation table and the reorder buffer. No dependencies.
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule

@@ design/tsr_ctrl.sv @@
// Controller state machine of the TCP stream reorder block.
// Sequences the datapath through clearing, lookup, delivery, release, purge and status steps.
// Depends on tsr_pkg.
module tsr_ctrl import tsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     seg_valid,
	output logic     seg_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [14:0] {
		S_CLR   = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_DISP  = 15'b000000000000100,
		S_STAT  = 15'b000000000001000,
		S_CSCAN = 15'b000000000010000,
		S_CDEC  = 15'b000000000100000,
		S_DIR   = 15'b000000001000000,
		S_CMP   = 15'b000000010000000,
		S_RSCAN = 15'b000000100000000,
		S_RDLV  = 15'b000001000000000,
		S_PSCAN = 15'b000010000000000,
		S_ENDS  = 15'b000100000000000,
		S_CLOSE = 15'b001000000000000,
		S_WB    = 15'b010000000000000,
		S_LAST  = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		seg_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				if (stat.sweep_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.sweep = 1'b1;
				end
			end
			S_IDLE: begin
				seg_ready = 1'b1;
				if (seg_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.op)
					OP_START: begin
						cmd.start_clr = 1'b1;
						state_d       = S_STAT;
					end
					OP_FINISH: state_d = S_STAT;
					OP_SEGMENT: begin
						cmd.cscan_rst = 1'b1;
						state_d       = S_CSCAN;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_STAT: begin
				if (stat.can_load) begin
					cmd.status = 1'b1;
					state_d    = S_LAST;
				end
			end
			S_CSCAN: begin
				if (stat.cscan_done) begin
					state_d = S_CDEC;
				end else begin
					cmd.cscan = 1'b1;
				end
			end
			S_CDEC: begin
				if (stat.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = S_DIR;
				end else if (stat.close || !stat.conv_free) begin
					cmd.absorb        = 1'b1;
					cmd.absorb_noconv = 1'b1;
					cmd.absorb_ovf    = !stat.close;
					state_d           = S_LAST;
				end else begin
					cmd.take_new = 1'b1;
					state_d      = S_DIR;
				end
			end
			S_DIR: begin
				cmd.dir = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (stat.seq_eq) begin
					cmd.deliver_in = 1'b1;
					cmd.hscan_rst  = 1'b1;
					state_d        = S_RSCAN;
				end else begin
					cmd.absorb     = 1'b1;
					cmd.hold_ins   = !stat.seq_older && stat.hold_free;
					cmd.absorb_ovf = !stat.seq_older && !stat.hold_free;
					state_d        = S_ENDS;
				end
			end
			S_RSCAN: begin
				if (stat.found) begin
					state_d = S_RDLV;
				end else if (stat.hscan_done) begin
					state_d = S_ENDS;
				end else begin
					cmd.hscan_find = 1'b1;
				end
			end
			S_RDLV: begin
				if (stat.can_load) begin
					cmd.deliver_held = 1'b1;
					cmd.hscan_rst    = 1'b1;
					state_d          = stat.held_moves ? S_PSCAN : S_RSCAN;
				end
			end
			S_PSCAN: begin
				if (stat.hscan_done) begin
					cmd.hscan_rst = 1'b1;
					state_d       = S_RSCAN;
				end else begin
					cmd.purge_dup = 1'b1;
				end
			end
			S_ENDS: begin
				if (stat.close) begin
					cmd.hscan_rst = 1'b1;
					state_d       = S_CLOSE;
				end else begin
					state_d = S_WB;
				end
			end
			S_CLOSE: begin
				if (stat.hscan_done) begin
					state_d = S_WB;
				end else begin
					cmd.purge_conv = 1'b1;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_LAST;
			end
			S_LAST: begin
				if (stat.can_push) begin
					cmd.push_last = 1'b1;
					if (stat.op == OP_START || stat.op == OP_FINISH) begin
						cmd.tables_clr = 1'b1;
						cmd.sweep_rst  = 1'b1;
						state_d        = S_CLR;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_CLR;
		endcase
	end
endmodule

@@ design/tsr_dp.sv @@
// Datapath of the TCP stream reorder block: item registers, conversation
// table and reorder buffer memories, counters and the result registers.
// Depends on tsr_pkg and tsr_ram.
module tsr_dp import tsr_pkg::*; #(
	parameter int CONV_SLOTS    = 64,
	parameter int HOLD_SLOTS    = 16,
	parameter int TICK_INTERVAL = 1000
) (
	input  logic     clk,
	input  logic     arst_n,
	input  seg_t     seg,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     res_valid,
	input  logic     res_ready,
	output res_t     res
);
	localparam int CIW = $clog2(CONV_SLOTS);
	localparam int CCW = $clog2(CONV_SLOTS + 1);
	localparam int HIW = HOLD_SLOTS > 1 ? $clog2(HOLD_SLOTS) : 1;
	localparam int HCW = $clog2(HOLD_SLOTS + 1);
	localparam int HDW = CIW + 66;
	localparam int RW  = $clog2(TICK_INTERVAL + 1);
	localparam int CEW = $bits(conv_ent_t);

	seg_t              item_q;
	logic              fin_pend_q;
	logic [CCW-1:0]    sw_q;
	logic [CCW-1:0]    ccnt_q;
	logic              cv_s1;
	logic [CIW-1:0]    cidx_s1;
	logic              hit_q;
	logic [CIW-1:0]    hit_idx_q;
	conv_ent_t         hit_ent_q;
	logic              free_v_q;
	logic [CIW-1:0]    free_idx_q;
	conv_ent_t         ent_q;
	logic [CIW-1:0]    ci_q;
	logic              up_q;
	logic              started_q;
	logic [31:0]       serial_q;
	logic [31:0]       total_q;
	logic [RW-1:0]     rem_q;
	logic              held_valid_q [HOLD_SLOTS];
	logic [HCW-1:0]    hcnt_q;
	logic              hv_s1;
	logic [HIW-1:0]    hidx_s1;
	logic              found_q;
	logic [HIW-1:0]    found_idx_q;
	logic              found_syn_q;
	logic [15:0]       found_len_q;
	logic [15:0]       found_tag_q;
	logic [31:0]       old_q;
	logic              pend_v_q;
	res_t              pend_q;
	logic              out_v_q;
	res_t              out_q;

	logic [CEW-1:0]    crd;
	conv_ent_t         cent;
	logic              c_we;
	logic [CIW-1:0]    c_waddr;
	conv_ent_t         c_wdata;
	logic [HDW-1:0]    hrd;
	logic [HDW-1:0]    h_wdata;
	logic [CIW-1:0]    rd_conv;
	logic              rd_up;
	logic              rd_syn;
	logic [31:0]       rd_seq;
	logic [15:0]       rd_len;
	logic [15:0]       rd_tag;
	logic [31:0]       fwd;
	logic [31:0]       rev;
	logic              c_match;
	logic [31:0]       cur_next;
	logic              dir_up;
	logic              hfree_v;
	logic [HIW-1:0]    hfree_idx;
	logic              hv_conv;
	logic              m_rel;
	logic              m_dup;
	logic [31:0]       tot_inc;
	logic [RW-1:0]     rem_inc;
	logic              load;
	res_t              new_res;
	logic [31:0]       seq_diff;
	logic [31:0]       adv_in;
	logic [31:0]       adv_held;
	conv_ent_t         ent_d;
	res_t              last_res;

	assign fwd = {item_q.src_port, item_q.dst_port};
	assign rev = {item_q.dst_port, item_q.src_port};

	assign c_we    = cmd.sweep || cmd.wb;
	assign c_waddr = cmd.sweep ? sw_q[CIW-1:0] : ci_q;
	always_comb begin
		c_wdata       = ent_q;
		c_wdata.valid = !(item_q.fin_flag || item_q.rst_flag);
		if (cmd.sweep) begin
			c_wdata = '0;
		end
	end

	tsr_ram #(.WIDTH(CEW), .DEPTH(CONV_SLOTS)) u_conv_ram (
		.clk    (clk),
		.we     (c_we),
		.waddr  (c_waddr),
		.wdata  (c_wdata),
		.raddr  (ccnt_q[CIW-1:0]),
		.rdata_q(crd)
	);
	assign cent = conv_ent_t'(crd);

	assign h_wdata = {ci_q, up_q, item_q.syn_flag, item_q.seq_num, item_q.payload_len,
		item_q.packet_tag};

	tsr_ram #(.WIDTH(HDW), .DEPTH(HOLD_SLOTS)) u_hold_ram (
		.clk    (clk),
		.we     (cmd.hold_ins),
		.waddr  (hfree_idx),
		.wdata  (h_wdata),
		.raddr  (hcnt_q[HIW-1:0]),
		.rdata_q(hrd)
	);
	assign rd_conv = hrd[HDW-1 -: CIW];
	assign rd_up   = hrd[65];
	assign rd_syn  = hrd[64];
	assign rd_seq  = hrd[63:32];
	assign rd_len  = hrd[31:16];
	assign rd_tag  = hrd[15:0];

	assign c_match = cent.valid &&
		((cent.client_addr == item_q.src_addr && cent.server_addr == item_q.dst_addr &&
		  cent.port_pair == fwd) ||
		 (cent.client_addr == item_q.dst_addr && cent.server_addr == item_q.src_addr &&
		  cent.port_pair == rev));

	assign cur_next = up_q ? ent_q.next_up : ent_q.next_down;
	assign dir_up   = ent_q.client_addr == item_q.src_addr && ent_q.port_pair == fwd;
	assign seq_diff = item_q.seq_num - cur_next;
	assign adv_in   = item_q.syn_flag ? 32'd1 : {16'd0, item_q.payload_len};
	assign adv_held = found_syn_q ? 32'd1 : {16'd0, found_len_q};

	always_comb begin
		hfree_v   = 1'b0;
		hfree_idx = '0;
		for (int i = HOLD_SLOTS - 1; i >= 0; i--) begin
			if (!held_valid_q[i]) begin
				hfree_v   = 1'b1;
				hfree_idx = HIW'(i);
			end
		end
	end

	assign hv_conv = hv_s1 && held_valid_q[hidx_s1] && rd_conv == ci_q;
	assign m_rel   = hv_conv && rd_up == up_q && rd_seq == cur_next;
	assign m_dup   = hv_conv && rd_up == up_q && rd_seq == old_q;

	assign tot_inc = total_q + 32'd1;
	assign rem_inc = (tot_inc == 32'd0 || rem_q == RW'(TICK_INTERVAL - 1)) ? '0 : rem_q + 1'b1;

	assign load = cmd.status || cmd.absorb || cmd.deliver_in || cmd.deliver_held;

	always_comb begin
		new_res                 = '0;
		new_res.delivered_count = total_q;
		if (cmd.status) begin
			new_res.result_kind = KIND_STATUS;
			new_res.count_tick  = 1'b1;
		end else if (cmd.absorb) begin
			new_res.result_kind  = KIND_ABSORB;
			new_res.out_tag      = item_q.packet_tag;
			new_res.overflow     = cmd.absorb_ovf;
			if (!cmd.absorb_noconv) begin
				new_res.conv_serial  = ent_q.conv_number;
				new_res.upstream     = up_q;
				new_res.conv_started = started_q;
			end
		end else begin
			new_res.result_kind     = KIND_DELIVER;
			new_res.out_tag         = cmd.deliver_held ? found_tag_q : item_q.packet_tag;
			new_res.conv_serial     = ent_q.conv_number;
			new_res.upstream        = up_q;
			new_res.conv_started    = cmd.deliver_in && started_q;
			new_res.delivered_count = tot_inc;
			new_res.count_tick      = rem_inc == '0;
		end
	end

	always_comb begin
		ent_d = ent_q;
		if (cmd.take_hit) begin
			ent_d = hit_ent_q;
		end else if (cmd.take_new) begin
			ent_d             = '0;
			ent_d.valid       = 1'b1;
			ent_d.client_addr = item_q.src_addr;
			ent_d.server_addr = item_q.dst_addr;
			ent_d.port_pair   = fwd;
			ent_d.conv_number = serial_q;
		end else if (cmd.dir) begin
			if (dir_up && !ent_q.up_known) begin
				ent_d.next_up  = item_q.seq_num;
				ent_d.up_known = 1'b1;
			end
			if (!dir_up && !ent_q.down_known) begin
				ent_d.next_down  = item_q.seq_num;
				ent_d.down_known = 1'b1;
			end
		end else if (cmd.deliver_in || cmd.deliver_held) begin
			if (up_q) begin
				ent_d.next_up = cur_next + (cmd.deliver_held ? adv_held : adv_in);
			end else begin
				ent_d.next_down = cur_next + (cmd.deliver_held ? adv_held : adv_in);
			end
		end
	end

	always_comb begin
		last_res               = pend_q;
		last_res.last          = 1'b1;
		last_res.conv_finished = fin_pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q       <= '0;
			ccnt_q     <= '0;
			cv_s1      <= 1'b0;
			hit_q      <= 1'b0;
			free_v_q   <= 1'b0;
			serial_q   <= '0;
			total_q    <= '0;
			rem_q      <= '0;
			hcnt_q     <= '0;
			hv_s1      <= 1'b0;
			found_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			fin_pend_q <= 1'b0;
			for (int i = 0; i < HOLD_SLOTS; i++) begin
				held_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.sweep_rst) begin
				sw_q <= '0;
			end else if (cmd.sweep) begin
				sw_q <= sw_q + 1'b1;
			end

			if (cmd.capture) begin
				fin_pend_q <= 1'b0;
			end else if (cmd.wb) begin
				fin_pend_q <= item_q.fin_flag || item_q.rst_flag;
			end

			cv_s1 <= cmd.cscan && ccnt_q != CCW'(CONV_SLOTS);
			if (cmd.cscan_rst) begin
				ccnt_q   <= '0;
				hit_q    <= 1'b0;
				free_v_q <= 1'b0;
			end else begin
				if (cmd.cscan && ccnt_q != CCW'(CONV_SLOTS)) begin
					ccnt_q <= ccnt_q + 1'b1;
				end
				if (cv_s1 && c_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cv_s1 && !cent.valid && !free_v_q) begin
					free_v_q <= 1'b1;
				end
			end

			if (cmd.start_clr) begin
				serial_q <= '0;
				total_q  <= '0;
				rem_q    <= '0;
			end else begin
				if (cmd.take_new) begin
					serial_q <= serial_q + 32'd1;
				end
				if (cmd.deliver_in || cmd.deliver_held) begin
					total_q <= tot_inc;
					rem_q   <= rem_inc;
				end
			end

			hv_s1 <= (cmd.hscan_find || cmd.purge_dup || cmd.purge_conv) &&
				hcnt_q != HCW'(HOLD_SLOTS);
			if (cmd.hscan_rst) begin
				hcnt_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if ((cmd.hscan_find || cmd.purge_dup || cmd.purge_conv) &&
				    hcnt_q != HCW'(HOLD_SLOTS)) begin
					hcnt_q <= hcnt_q + 1'b1;
				end
				if (cmd.hscan_find && m_rel && !found_q) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.tables_clr) begin
				for (int i = 0; i < HOLD_SLOTS; i++) begin
					held_valid_q[i] <= 1'b0;
				end
			end else if (cmd.hold_ins) begin
				held_valid_q[hfree_idx] <= 1'b1;
			end else if (cmd.deliver_held) begin
				held_valid_q[found_idx_q] <= 1'b0;
			end else if ((cmd.purge_dup && m_dup) || (cmd.purge_conv && hv_conv)) begin
				held_valid_q[hidx_s1] <= 1'b0;
			end

			if (load) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end else if (res_ready) begin
					out_v_q <= 1'b0;
				end
			end else if (cmd.push_last) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= seg;
		end
		cidx_s1 <= ccnt_q[CIW-1:0];
		hidx_s1 <= hcnt_q[HIW-1:0];
		if (!cmd.cscan_rst && cv_s1 && c_match && !hit_q) begin
			hit_idx_q <= cidx_s1;
			hit_ent_q <= cent;
		end
		if (!cmd.cscan_rst && cv_s1 && !cent.valid && !free_v_q) begin
			free_idx_q <= cidx_s1;
		end
		if (!cmd.hscan_rst && cmd.hscan_find && m_rel && !found_q) begin
			found_idx_q <= hidx_s1;
			found_syn_q <= rd_syn;
			found_len_q <= rd_len;
			found_tag_q <= rd_tag;
		end

		if (cmd.take_hit) begin
			ci_q      <= hit_idx_q;
			started_q <= 1'b0;
		end else if (cmd.take_new) begin
			ci_q      <= free_idx_q;
			started_q <= 1'b1;
		end else if (cmd.dir) begin
			up_q <= dir_up;
		end
		ent_q <= ent_d;
		if (cmd.deliver_held) begin
			old_q <= cur_next;
		end

		if (load) begin
			pend_q <= new_res;
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end else if (cmd.push_last) begin
			out_q <= last_res;
		end
	end

	assign stat.op         = item_q.opcode;
	assign stat.close      = item_q.fin_flag || item_q.rst_flag;
	assign stat.sweep_done = sw_q == CCW'(CONV_SLOTS);
	assign stat.cscan_done = ccnt_q == CCW'(CONV_SLOTS) && !cv_s1;
	assign stat.hit        = hit_q;
	assign stat.conv_free  = free_v_q;
	assign stat.seq_eq     = item_q.seq_num == cur_next;
	assign stat.seq_older  = seq_diff[31];
	assign stat.hold_free  = hfree_v;
	assign stat.hscan_done = hcnt_q == HCW'(HOLD_SLOTS) && !hv_s1;
	assign stat.found      = found_q;
	assign stat.held_moves = found_syn_q || found_len_q != 16'd0;
	assign stat.can_load   = !pend_v_q || !out_v_q || res_ready;
	assign stat.can_push   = !out_v_q || res_ready;

	assign res_valid = out_v_q;
	assign res       = out_q;
endmodule

@@ design/tcp_stream_reorder.sv @@
// A segment goes through the serial conversation table scan and decision, then
// through reorder buffer passes (each release and each purge is one pass); a new
// request is taken only when the previous one is done.
// Capture start and finish end with a clearing sweep of the conversation table.
// After reset the table is swept clear before the first request is taken.
module tcp_stream_reorder import tsr_pkg::*; #(
	parameter int CONV_SLOTS    = 64,
	parameter int HOLD_SLOTS    = 16,
	parameter int TICK_INTERVAL = 1000
) (
	input logic       clk,
	input logic       arst_n,
	tsr_seg_if.sink   seg,
	tsr_res_if.source res
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	seg_t     seg_data;
	res_t     res_data;

	assign seg_data.opcode      = seg.opcode;
	assign seg_data.src_addr    = seg.src_addr;
	assign seg_data.dst_addr    = seg.dst_addr;
	assign seg_data.src_port    = seg.src_port;
	assign seg_data.dst_port    = seg.dst_port;
	assign seg_data.seq_num     = seg.seq_num;
	assign seg_data.payload_len = seg.payload_len;
	assign seg_data.syn_flag    = seg.syn_flag;
	assign seg_data.fin_flag    = seg.fin_flag;
	assign seg_data.rst_flag    = seg.rst_flag;
	assign seg_data.packet_tag  = seg.packet_tag;

	tsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg_valid(seg.valid),
		.seg_ready(seg.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tsr_dp #(
		.CONV_SLOTS   (CONV_SLOTS),
		.HOLD_SLOTS   (HOLD_SLOTS),
		.TICK_INTERVAL(TICK_INTERVAL)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg      (seg_data),
		.cmd      (cmd),
		.stat     (stat),
		.res_valid(res.valid),
		.res_ready(res.ready),
		.res      (res_data)
	);

	assign res.result_kind     = res_data.result_kind;
	assign res.out_tag         = res_data.out_tag;
	assign res.conv_serial     = res_data.conv_serial;
	assign res.upstream        = res_data.upstream;
	assign res.conv_started    = res_data.conv_started;
	assign res.conv_finished   = res_data.conv_finished;
	assign res.delivered_count = res_data.delivered_count;
	assign res.count_tick      = res_data.count_tick;
	assign res.overflow        = res_data.overflow;
	assign res.last            = res_data.last;

`ifndef ASSERT_OFF
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.ready |=> !seg.ready)
		else $error("second request taken while one is in progress");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.result_kind == KIND_STATUS |-> res.last && res.count_tick)
		else $error("status result without last or tick");
	a_started_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.conv_started |-> res.result_kind != KIND_STATUS)
		else $error("status result marks a started conversation");
	a_ovf_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.overflow |-> res.result_kind == KIND_ABSORB)
		else $error("overflow on a result that is not a drop");
`endif
endmodule

@@ sim/tsr_checker.sv @@
// Checker for the TCP stream reorder block: watches both request channels,
// predicts the results of every accepted input request and compares them.
// Depends on tsr_pkg and the channel interfaces in tsr_if.sv.
module tsr_checker import tsr_pkg::*; #(
	parameter int CONV_SLOTS    = 64,
	parameter int HOLD_SLOTS    = 16,
	parameter int TICK_INTERVAL = 1000
) (
	input  logic clk,
	input  logic arst_n,
	tsr_seg_if   seg,
	tsr_res_if   res,
	output int   errors,
	output int   pending
);

	typedef struct {
		int          conv;
		logic        up;
		logic        syn;
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] tag;
	} held_seg_t;

	logic        conv_live [CONV_SLOTS];
	logic [31:0] client_ip [CONV_SLOTS];
	logic [31:0] server_ip [CONV_SLOTS];
	logic [31:0] port_pair [CONV_SLOTS];
	logic [31:0] conv_id   [CONV_SLOTS];
	logic [31:0] up_next   [CONV_SLOTS];
	logic [31:0] down_next [CONV_SLOTS];
	logic        up_known  [CONV_SLOTS];
	logic        down_known[CONV_SLOTS];
	logic        held_live [HOLD_SLOTS];
	held_seg_t   held_seg  [HOLD_SLOTS];
	logic [31:0] delivered_total;
	logic [31:0] next_serial;
	res_t        expected_results[$];

	task automatic clear_tables();
		for (int i = 0; i < CONV_SLOTS; i++) begin
			conv_live[i] = 1'b0;
			up_known[i] = 1'b0;
			down_known[i] = 1'b0;
		end
		for (int h = 0; h < HOLD_SLOTS; h++)
			held_live[h] = 1'b0;
	endtask

	task automatic add_result(input logic [1:0] kind, input logic [15:0] tag,
			input logic [31:0] serial, input logic up, input logic started,
			input logic tick, input logic ovf);
		res_t r;
		r = '0;
		r.result_kind = kind;
		r.out_tag = tag;
		r.conv_serial = serial;
		r.upstream = up;
		r.conv_started = started;
		r.delivered_count = delivered_total;
		r.count_tick = tick;
		r.overflow = ovf;
		expected_results.push_back(r);
	endtask

	task automatic add_delivery(input logic [15:0] tag, input logic [31:0] serial,
			input logic up, input logic started);
		delivered_total++;
		add_result(KIND_DELIVER, tag, serial, up, started,
			(delivered_total % TICK_INTERVAL) == 0, 1'b0);
	endtask

	task automatic close_last(input logic finished);
		res_t r;
		r = expected_results.pop_back();
		r.last = 1'b1;
		r.conv_finished = finished;
		expected_results.push_back(r);
	endtask

	function automatic logic [31:0] seq_step(input logic syn, input logic [15:0] len);
		return syn ? 32'd1 : {16'd0, len};
	endfunction

	task automatic predict_segment(input seg_t s);
		int          ci;
		int          f;
		logic        up;
		logic        started;
		logic [31:0] fwd;
		logic [31:0] rev;
		logic [31:0] serial;
		logic [31:0] nxt;
		logic [31:0] old;
		logic [31:0] diff;
		ci = -1;
		started = 1'b0;
		fwd = {s.src_port, s.dst_port};
		rev = {s.dst_port, s.src_port};
		for (int i = 0; i < CONV_SLOTS; i++)
			if (ci < 0 && conv_live[i] &&
					((client_ip[i] == s.src_addr && server_ip[i] == s.dst_addr &&
					port_pair[i] == fwd) || (client_ip[i] == s.dst_addr &&
					server_ip[i] == s.src_addr && port_pair[i] == rev)))
				ci = i;
		if (ci < 0) begin
			if (s.fin_flag || s.rst_flag) begin
				add_result(KIND_ABSORB, s.packet_tag, '0, 1'b0, 1'b0, 1'b0, 1'b0);
				close_last(1'b0);
				return;
			end
			for (int i = 0; i < CONV_SLOTS; i++)
				if (ci < 0 && !conv_live[i])
					ci = i;
			if (ci < 0) begin
				add_result(KIND_ABSORB, s.packet_tag, '0, 1'b0, 1'b0, 1'b0, 1'b1);
				close_last(1'b0);
				return;
			end
			conv_live[ci] = 1'b1;
			client_ip[ci] = s.src_addr;
			server_ip[ci] = s.dst_addr;
			port_pair[ci] = fwd;
			conv_id[ci] = next_serial;
			next_serial++;
			up_known[ci] = 1'b0;
			down_known[ci] = 1'b0;
			started = 1'b1;
		end
		serial = conv_id[ci];
		up = client_ip[ci] == s.src_addr && port_pair[ci] == fwd;
		if (up) begin
			if (!up_known[ci]) begin
				up_next[ci] = s.seq_num;
				up_known[ci] = 1'b1;
			end
			nxt = up_next[ci];
		end else begin
			if (!down_known[ci]) begin
				down_next[ci] = s.seq_num;
				down_known[ci] = 1'b1;
			end
			nxt = down_next[ci];
		end
		diff = s.seq_num - nxt;
		if (s.seq_num == nxt) begin
			add_delivery(s.packet_tag, serial, up, started);
			nxt += seq_step(s.syn_flag, s.payload_len);
			while (1) begin
				f = -1;
				for (int h = 0; h < HOLD_SLOTS; h++)
					if (f < 0 && held_live[h] && held_seg[h].conv == ci &&
							held_seg[h].up == up && held_seg[h].seq == nxt)
						f = h;
				if (f < 0)
					break;
				held_live[f] = 1'b0;
				old = nxt;
				add_delivery(held_seg[f].tag, serial, up, 1'b0);
				nxt += seq_step(held_seg[f].syn, held_seg[f].len);
				if (nxt != old)
					for (int h = 0; h < HOLD_SLOTS; h++)
						if (held_live[h] && held_seg[h].conv == ci &&
								held_seg[h].up == up && held_seg[h].seq == old)
							held_live[h] = 1'b0;
			end
		end else if (diff[31]) begin
			add_result(KIND_ABSORB, s.packet_tag, serial, up, started, 1'b0, 1'b0);
		end else begin
			f = -1;
			for (int h = 0; h < HOLD_SLOTS; h++)
				if (f < 0 && !held_live[h])
					f = h;
			if (f < 0) begin
				add_result(KIND_ABSORB, s.packet_tag, serial, up, started, 1'b0, 1'b1);
			end else begin
				held_live[f] = 1'b1;
				held_seg[f] = '{ci, up, s.syn_flag, s.seq_num, s.payload_len,
					s.packet_tag};
				add_result(KIND_ABSORB, s.packet_tag, serial, up, started, 1'b0, 1'b0);
			end
		end
		if (up)
			up_next[ci] = nxt;
		else
			down_next[ci] = nxt;
		if (s.fin_flag || s.rst_flag) begin
			conv_live[ci] = 1'b0;
			for (int h = 0; h < HOLD_SLOTS; h++)
				if (held_live[h] && held_seg[h].conv == ci)
					held_live[h] = 1'b0;
		end
		close_last(s.fin_flag || s.rst_flag);
	endtask

	task automatic predict_request(input seg_t s);
		case (s.opcode)
			OP_START: begin
				clear_tables();
				delivered_total = '0;
				next_serial = '0;
				add_result(KIND_STATUS, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
				close_last(1'b0);
			end
			OP_FINISH: begin
				add_result(KIND_STATUS, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
				close_last(1'b0);
				clear_tables();
			end
			OP_SEGMENT: predict_segment(s);
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (expected_results.size() == 0) begin
			report("result with nothing expected, tag", 32'(got.out_tag), '0);
			return;
		end
		want = expected_results.pop_front();
		if (got.result_kind !== want.result_kind)
			report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
		if (got.out_tag !== want.out_tag)
			report("out_tag", 32'(got.out_tag), 32'(want.out_tag));
		if (got.conv_serial !== want.conv_serial)
			report("conv_serial", got.conv_serial, want.conv_serial);
		if (got.upstream !== want.upstream)
			report("upstream", 32'(got.upstream), 32'(want.upstream));
		if (got.conv_started !== want.conv_started)
			report("conv_started", 32'(got.conv_started), 32'(want.conv_started));
		if (got.conv_finished !== want.conv_finished)
			report("conv_finished", 32'(got.conv_finished), 32'(want.conv_finished));
		if (got.delivered_count !== want.delivered_count)
			report("delivered_count", got.delivered_count, want.delivered_count);
		if (got.count_tick !== want.count_tick)
			report("count_tick", 32'(got.count_tick), 32'(want.count_tick));
		if (got.overflow !== want.overflow)
			report("overflow", 32'(got.overflow), 32'(want.overflow));
		if (got.last !== want.last)
			report("last", 32'(got.last), 32'(want.last));
	endtask

	initial begin
		errors = 0;
		pending = 0;
		delivered_total = '0;
		next_serial = '0;
		clear_tables();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (seg.valid && seg.ready)
				predict_request('{seg.opcode, seg.src_addr, seg.dst_addr, seg.src_port,
					seg.dst_port, seg.seq_num, seg.payload_len, seg.syn_flag,
					seg.fin_flag, seg.rst_flag, seg.packet_tag});
			if (res.valid && res.ready)
				check_result('{res.result_kind, res.out_tag, res.conv_serial, res.upstream,
					res.conv_started, res.conv_finished, res.delivered_count,
					res.count_tick, res.overflow, res.last});
			pending <= expected_results.size();
		end
	end

endmodule

@@ sim/tb_tcp_stream_reorder.sv @@
// Testbench top for the TCP stream reorder block: drives directed and random
// segment and capture requests, stalls the result side and gives the verdict.
// Depends on tsr_pkg, tsr_if.sv, tsr_checker and tcp_stream_reorder.
module tb_tcp_stream_reorder;
	import tsr_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int FLOWS = 6;
	localparam int ITEMS = 420;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [31:0] client;
		logic [31:0] server;
		logic [15:0] cport;
		logic [15:0] sport;
		logic [31:0] cur_up;
		logic [31:0] cur_down;
	} flow_t;

	logic  clk;
	logic  arst_n;
	int    errors;
	int    pending;
	int    sent;
	int    idle_cycles;
	int    stall_left;
	logic  calm;
	flow_t flows[FLOWS];

	tsr_seg_if seg();
	tsr_res_if res();

	tcp_stream_reorder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.res    (res)
	);

	tsr_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.seg     (seg),
		.res     (res),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			res.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res.ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		if ((seg.valid && seg.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(input seg_t s);
		int gap;
		seg.opcode <= s.opcode;
		seg.src_addr <= s.src_addr;
		seg.dst_addr <= s.dst_addr;
		seg.src_port <= s.src_port;
		seg.dst_port <= s.dst_port;
		seg.seq_num <= s.seq_num;
		seg.payload_len <= s.payload_len;
		seg.syn_flag <= s.syn_flag;
		seg.fin_flag <= s.fin_flag;
		seg.rst_flag <= s.rst_flag;
		seg.packet_tag <= s.packet_tag;
		seg.valid <= 1'b1;
		do
			@(posedge clk);
		while (!seg.ready);
		sent++;
		gap = 0;
		if (!calm)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
				($urandom_range(0, 1) ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic seg_t capture(input logic [1:0] op);
		seg_t s;
		s = '0;
		s.opcode = op;
		s.packet_tag = 16'($urandom_range(0, 65535));
		return s;
	endfunction

	function automatic seg_t random_seg();
		seg_t s;
		s.opcode = OP_SEGMENT;
		s.src_addr = $urandom;
		s.dst_addr = $urandom;
		s.src_port = 16'($urandom);
		s.dst_port = 16'($urandom);
		s.seq_num = $urandom;
		s.payload_len = 16'($urandom);
		s.syn_flag = 1'($urandom);
		s.fin_flag = 1'($urandom);
		s.rst_flag = 1'($urandom);
		s.packet_tag = 16'($urandom);
		return s;
	endfunction

	function automatic seg_t on_flow(input int k, input logic up, input logic [31:0] seq,
			input logic [15:0] len, input logic syn, input logic fin, input logic rst);
		seg_t s;
		s.opcode = OP_SEGMENT;
		s.src_addr = up ? flows[k].client : flows[k].server;
		s.dst_addr = up ? flows[k].server : flows[k].client;
		s.src_port = up ? flows[k].cport : flows[k].sport;
		s.dst_port = up ? flows[k].sport : flows[k].cport;
		s.seq_num = seq;
		s.payload_len = len;
		s.syn_flag = syn;
		s.fin_flag = fin;
		s.rst_flag = rst;
		s.packet_tag = 16'($urandom_range(0, 65535));
		return s;
	endfunction

	task automatic new_flow(input int k);
		flows[k].client = $urandom;
		flows[k].server = flows[k].client ^ (32'h1 << $urandom_range(0, 31));
		flows[k].cport = 16'($urandom_range(0, 65535));
		flows[k].sport = 16'($urandom_range(0, 65535));
		flows[k].cur_up = $urandom;
		flows[k].cur_down = $urandom;
	endtask

	task automatic burst();
		int          k;
		int          n;
		int          j;
		logic        up;
		logic        closing;
		logic [31:0] cur;
		seg_t        items[$];
		seg_t        t;
		logic [15:0] len;
		logic        syn;
		k = $urandom_range(0, FLOWS - 1);
		up = 1'($urandom_range(0, 1));
		n = $urandom_range(1, 4);
		cur = up ? flows[k].cur_up : flows[k].cur_down;
		for (int i = 0; i < n; i++) begin
			syn = $urandom_range(0, 9) == 0;
			len = ($urandom_range(0, 14) == 0) ? 16'($urandom_range(0, 65535)) :
				16'($urandom_range(0, 64));
			items.push_back(on_flow(k, up, cur, len, syn, 1'b0, 1'b0));
			cur += syn ? 32'd1 : {16'd0, len};
		end
		if (up)
			flows[k].cur_up = cur;
		else
			flows[k].cur_down = cur;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = items[i];
			items[i] = items[j];
			items[j] = t;
		end
		if ($urandom_range(0, 5) == 0)
			items.push_back(items[$urandom_range(0, n - 1)]);
		closing = $urandom_range(0, 9) == 0;
		if (closing) begin
			t = items.pop_back();
			t.fin_flag = 1'($urandom_range(0, 1));
			t.rst_flag = !t.fin_flag || $urandom_range(0, 3) == 0;
			items.push_back(t);
		end
		foreach (items[i])
			send(items[i]);
		if (closing)
			new_flow(k);
	endtask

	task automatic noise();
		seg_t s;
		int   k;
		logic up;
		case ($urandom_range(0, 3))
			0: begin
				s = random_seg();
				send(s);
			end
			1: begin
				k = $urandom_range(0, FLOWS - 1);
				up = 1'($urandom_range(0, 1));
				s = on_flow(k, up, (up ? flows[k].cur_up : flows[k].cur_down) -
					$urandom_range(1, 5000), 16'($urandom_range(0, 64)), 1'b0, 1'b0, 1'b0);
				send(s);
			end
			2: send(capture(OP_SPARE));
			default: begin
				s = random_seg();
				s.fin_flag = 1'($urandom_range(0, 1));
				s.rst_flag = !s.fin_flag;
				send(s);
			end
		endcase
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic fill_table();
		seg_t s;
		send(capture(OP_START));
		for (int i = 0; i < 66; i++) begin
			s = random_seg();
			s.fin_flag = 1'b0;
			s.rst_flag = 1'b0;
			send(s);
		end
		send(capture(OP_START));
	endtask

	task automatic fill_buffer();
		int          k;
		logic [31:0] cur;
		k = $urandom_range(0, FLOWS - 1);
		cur = flows[k].cur_up;
		send(on_flow(k, 1'b1, cur, 16'd10, 1'b0, 1'b0, 1'b0));
		cur += 32'd10;
		for (int i = 1; i <= 18; i++)
			send(on_flow(k, 1'b1, cur + 100 * i, 16'd5, 1'b0, 1'b0, 1'b0));
		send(on_flow(k, 1'b1, cur, 16'd5, 1'b0, 1'b0, 1'b1));
		new_flow(k);
	endtask

	task automatic directed();
		send(capture(OP_START));
		flows[0].client = '0;
		flows[0].server = '1;
		flows[0].cport = '0;
		flows[0].sport = '1;
		send(on_flow(0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0));
		send(on_flow(0, 1'b0, 32'h0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b1, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b1, 32'hFFFF_FFFE, 16'd1, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b0, 32'h0001_0004, 16'd4, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b0, 32'h0001_0004, 16'd4, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b0, 32'h0000_FFFF, 16'd5, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b1, 32'h0000_0010, 16'd1, 1'b0, 1'b0, 1'b0));
		send(on_flow(0, 1'b1, 32'h0, 16'd0, 1'b0, 1'b1, 1'b0));
		send(on_flow(0, 1'b1, 32'h5, 16'd0, 1'b0, 1'b1, 1'b0));
		send(on_flow(0, 1'b0, 32'h5, 16'd0, 1'b0, 1'b0, 1'b1));
		send(capture(OP_SPARE));
		send(on_flow(0, 1'b0, 32'h7, 16'd3, 1'b0, 1'b0, 1'b0));
		send(capture(OP_FINISH));
		send(on_flow(0, 1'b0, 32'h9, 16'd3, 1'b1, 1'b0, 1'b0));
		send(capture(OP_FINISH));
		send(capture(OP_START));
		new_flow(0);
	endtask

	initial begin
		logic table_done;
		logic buffer_done;
		int   r;
		arst_n = 1'b0;
		calm = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		sent = 0;
		table_done = 1'b0;
		buffer_done = 1'b0;
		res.ready = 1'b0;
		seg.valid = 1'b0;
		seg.opcode = OP_SEGMENT;
		seg.src_addr = '0;
		seg.dst_addr = '0;
		seg.src_port = '0;
		seg.dst_port = '0;
		seg.seq_num = '0;
		seg.payload_len = '0;
		seg.syn_flag = 1'b0;
		seg.fin_flag = 1'b0;
		seg.rst_flag = 1'b0;
		seg.packet_tag = '0;
		for (int k = 0; k < FLOWS; k++)
			new_flow(k);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		directed();
		while (sent < ITEMS) begin
			if (!table_done && sent > 150) begin
				table_done = 1'b1;
				fill_table();
			end
			if (!buffer_done && sent > 260) begin
				buffer_done = 1'b1;
				fill_buffer();
			end
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			r = $urandom_range(0, 99);
			if (r < 72) begin
				burst();
			end else if (r < 92) begin
				noise();
			end else if (r < 96) begin
				seg.valid <= 1'b0;
				wait_drained();
				send(capture(OP_FINISH));
			end else begin
				send(capture(OP_START));
			end
		end
		seg.valid <= 1'b0;
		calm = 1'b0;
		wait_drained();
		repeat (600) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
design/tsr_pkg.sv
design/tsr_if.sv
design/tsr_ram.sv
design/tsr_ctrl.sv
design/tsr_dp.sv
design/tcp_stream_reorder.sv
sim/tsr_checker.sv
sim/tb_tcp_stream_reorder.sv
